/* sv/ecmpfh_pkg.sv */
package ecmpfh_pkg;

	localparam int MAX_HOPS  = 8;
	localparam int PORT_BITS = 8;

	localparam int WORD_W  = 32;
	localparam int PROTO_W = 8;
	localparam int L4P_W   = 16;
	localparam int COUNT_W = 4;
	localparam int IDX_W   = 3;
	localparam int PORT_W  = 8;
	localparam int LIST_W  = 64;

	localparam logic [WORD_W-1:0] MM_C1   = 32'hcc9e2d51;
	localparam logic [WORD_W-1:0] MM_C2   = 32'h1b873593;
	localparam logic [WORD_W-1:0] MM_N    = 32'he6546b64;
	localparam logic [WORD_W-1:0] MM_F1   = 32'h85ebca6b;
	localparam logic [WORD_W-1:0] MM_F2   = 32'hc2b2ae35;
	localparam logic [WORD_W-1:0] KEY_LEN = 32'd12;

	localparam logic [PROTO_W-1:0] PROTO_TCP  = 8'h06;
	localparam logic [PROTO_W-1:0] PROTO_UDP  = 8'h11;
	localparam logic [PROTO_W-1:0] PROTO_ACK  = 8'hFC;
	localparam logic [PROTO_W-1:0] PROTO_NACK = 8'hFD;

	localparam logic [PORT_W-1:0] PORT_MASK = PORT_W'((1 << PORT_BITS) - 1);

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam int MOD_STAGES = 8;
	localparam int MOD_BITS   = WORD_W / MOD_STAGES;

	typedef struct packed {
		logic               ok;
		logic [COUNT_W-1:0] count;
		logic [LIST_W-1:0]  hop_list;
	} meta_t;

	typedef struct packed {
		logic [WORD_W-1:0] w0;
		logic [WORD_W-1:0] w1;
		logic [WORD_W-1:0] w2;
		meta_t             meta;
	} item_t;

	function automatic logic [WORD_W-1:0] rotl32(input logic [WORD_W-1:0] v,
		input int unsigned r);
		return (v << r) | (v >> (WORD_W - r));
	endfunction

	// k is already scrambled by C1, rotate 15 and C2
	function automatic logic [WORD_W-1:0] mix_block(input logic [WORD_W-1:0] h,
		input logic [WORD_W-1:0] k);
		logic [WORD_W-1:0] x;
		x = rotl32(h ^ k, 13);
		return (x << 2) + x + MM_N;
	endfunction

	// restoring remainder step over one nibble, MSB first; rem < cnt on entry
	function automatic logic [IDX_W-1:0] mod_step(input logic [IDX_W-1:0] rem,
		input logic [MOD_BITS-1:0] nib, input logic [COUNT_W-1:0] cnt);
		logic [COUNT_W-1:0] t;
		logic [IDX_W-1:0]   r;
		r = rem;
		for (int i = MOD_BITS - 1; i >= 0; i--) begin
			t = {r, nib[i]};
			if (t >= cnt) begin
				t = t - cnt;
			end
			r = t[IDX_W-1:0];
		end
		return r;
	endfunction

endpackage

/* sv/ecmp_flow_hash_nexthop_select_unit.sv */
// Accept to out_valid: queue, hash stages s1 to s8, mod stages, output register.
// Throughput: one beat per cycle when not stalled; one item per hash and mod stage.
// Latency is set by the chain of 32-bit multiplies and the 8-stage nibble-wise mod.
// A 2-entry queue decouples input accept from the pipeline, which stalls as a whole.
// Reset (arst_n low, async) empties the queue and pipeline and sets hash_seed to 0.
module ecmp_flow_hash_nexthop_select_unit
	import ecmpfh_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [WORD_W-1:0]  cfg_wdata,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [WORD_W-1:0]  source_address,
	input  logic [WORD_W-1:0]  dest_address,
	input  logic [PROTO_W-1:0] protocol,
	input  logic [L4P_W-1:0]   source_port,
	input  logic [L4P_W-1:0]   dest_port,
	input  logic [COUNT_W-1:0] hop_count,
	input  logic [LIST_W-1:0]  hop_list,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [PORT_W-1:0]  out_port,
	output logic [IDX_W-1:0]   hop_index,
	output logic [WORD_W-1:0]  flow_hash,
	output logic               bad_protocol
);

	logic [WORD_W-1:0] hash_seed_q;
	logic              push;
	item_t             push_item;
	logic              q_full;
	logic              q_valid;
	item_t             head;
	logic              pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_seed_q <= '0;
		end else if (cfg_we) begin
			hash_seed_q <= cfg_wdata;
		end
	end

	ecmpfh_front u_front (
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.source_address (source_address),
		.dest_address   (dest_address),
		.protocol       (protocol),
		.source_port    (source_port),
		.dest_port      (dest_port),
		.hop_count      (hop_count),
		.hop_list       (hop_list),
		.q_full         (q_full),
		.push           (push),
		.item           (push_item)
	);

	ecmpfh_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (q_full),
		.q_valid   (q_valid),
		.head      (head),
		.pop       (pop)
	);

	ecmpfh_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.seed         (hash_seed_q),
		.q_valid      (q_valid),
		.head         (head),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_port     (out_port),
		.hop_index    (hop_index),
		.flow_hash    (flow_hash),
		.bad_protocol (bad_protocol)
	);

endmodule

/* sv/ecmpfh_front.sv */
module ecmpfh_front
	import ecmpfh_pkg::*;
(
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [WORD_W-1:0]  source_address,
	input  logic [WORD_W-1:0]  dest_address,
	input  logic [PROTO_W-1:0] protocol,
	input  logic [L4P_W-1:0]   source_port,
	input  logic [L4P_W-1:0]   dest_port,
	input  logic [COUNT_W-1:0] hop_count,
	input  logic [LIST_W-1:0]  hop_list,
	input  logic               q_full,
	output logic               push,
	output item_t              item
);

	logic               ok;
	logic [COUNT_W-1:0] count;

	assign ok = (protocol == PROTO_TCP) || (protocol == PROTO_UDP) ||
		(protocol == PROTO_ACK) || (protocol == PROTO_NACK);

	always_comb begin
		priority if (hop_count == '0) begin
			count = COUNT_W'(1);
		end else if (hop_count > COUNT_W'(MAX_HOPS)) begin
			count = COUNT_W'(MAX_HOPS);
		end else begin
			count = hop_count;
		end
	end

	assign in_stall = q_full;
	assign push     = in_valid && !q_full;

	assign item.w0            = source_address;
	assign item.w1            = dest_address;
	assign item.w2            = {dest_port, source_port};
	assign item.meta.ok       = ok;
	assign item.meta.count    = count;
	assign item.meta.hop_list = hop_list;

endmodule

/* sv/ecmpfh_queue.sv */
module ecmpfh_queue
	import ecmpfh_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t push_item,
	output logic  full,
	output logic  q_valid,
	output item_t head,
	input  logic  pop
);

	item_t             mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;

	assign full    = (cnt_q == QCNT_W'(QUEUE_DEPTH));
	assign q_valid = (cnt_q != '0);
	assign head    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

/* sv/ecmpfh_back.sv */
module ecmpfh_back
	import ecmpfh_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic [WORD_W-1:0]  seed,
	input  logic               q_valid,
	input  item_t              head,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [PORT_W-1:0]  out_port,
	output logic [IDX_W-1:0]   hop_index,
	output logic [WORD_W-1:0]  flow_hash,
	output logic               bad_protocol
);

	logic en;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;
	meta_t meta_s1, meta_s2, meta_s3, meta_s4, meta_s5, meta_s6, meta_s7, meta_s8;

	logic [WORD_W-1:0] k0_s1, k1_s1, k2_s1;
	logic [WORD_W-1:0] k0_s2, k1_s2, k2_s2;
	logic [WORD_W-1:0] h_s3, k1_s3, k2_s3;
	logic [WORD_W-1:0] h_s4, k2_s4;
	logic [WORD_W-1:0] h_s5;
	logic [WORD_W-1:0] x_s6, x_s7, hash_s8;

	logic [WORD_W-1:0] fin0, fin1, fin2;

	logic              m_v    [MOD_STAGES];
	meta_t             m_meta [MOD_STAGES];
	logic [WORD_W-1:0] m_hash [MOD_STAGES];
	logic [IDX_W-1:0]  m_rem  [MOD_STAGES];

	logic              src_v    [MOD_STAGES];
	meta_t             src_meta [MOD_STAGES];
	logic [WORD_W-1:0] src_hash [MOD_STAGES];
	logic [IDX_W-1:0]  src_rem  [MOD_STAGES];

	logic              out_valid_q;
	logic [PORT_W-1:0] out_port_q;
	logic [IDX_W-1:0]  hop_index_q;
	logic [WORD_W-1:0] flow_hash_q;
	logic              bad_protocol_q;

	logic [IDX_W-1:0]  sel_idx;
	logic [LIST_W-1:0] sel_shift;
	meta_t             last_meta;

	assign en  = !out_valid_q || !out_stall;
	assign pop = q_valid && en;

	assign fin0 = h_s5 ^ KEY_LEN;
	assign fin1 = fin0 ^ (fin0 >> 16);
	assign fin2 = x_s6 ^ (x_s6 >> 13);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else if (en) begin
			v_s1 <= q_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			k0_s1   <= head.w0 * MM_C1;
			k1_s1   <= head.w1 * MM_C1;
			k2_s1   <= head.w2 * MM_C1;
			meta_s1 <= head.meta;

			k0_s2   <= rotl32(k0_s1, 15) * MM_C2;
			k1_s2   <= rotl32(k1_s1, 15) * MM_C2;
			k2_s2   <= rotl32(k2_s1, 15) * MM_C2;
			meta_s2 <= meta_s1;

			h_s3    <= mix_block(seed, k0_s2);
			k1_s3   <= k1_s2;
			k2_s3   <= k2_s2;
			meta_s3 <= meta_s2;

			h_s4    <= mix_block(h_s3, k1_s3);
			k2_s4   <= k2_s3;
			meta_s4 <= meta_s3;

			h_s5    <= mix_block(h_s4, k2_s4);
			meta_s5 <= meta_s4;

			x_s6    <= fin1 * MM_F1;
			meta_s6 <= meta_s5;

			x_s7    <= fin2 * MM_F2;
			meta_s7 <= meta_s6;

			hash_s8 <= x_s7 ^ (x_s7 >> 16);
			meta_s8 <= meta_s7;
		end
	end

	// hash mod count, one nibble per stage
	for (genvar j = 0; j < MOD_STAGES; j++) begin : g_mod
		if (j == 0) begin : g_first
			assign src_v[j]    = v_s8;
			assign src_meta[j] = meta_s8;
			assign src_hash[j] = hash_s8;
			assign src_rem[j]  = '0;
		end else begin : g_next
			assign src_v[j]    = m_v[j-1];
			assign src_meta[j] = m_meta[j-1];
			assign src_hash[j] = m_hash[j-1];
			assign src_rem[j]  = m_rem[j-1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				m_v[j] <= 1'b0;
			end else if (en) begin
				m_v[j] <= src_v[j];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				m_meta[j] <= src_meta[j];
				m_hash[j] <= src_hash[j];
				m_rem[j]  <= mod_step(src_rem[j],
					src_hash[j][WORD_W-1-MOD_BITS*j -: MOD_BITS], src_meta[j].count);
			end
		end
	end

	assign last_meta = m_meta[MOD_STAGES-1];
	assign sel_idx   = last_meta.ok ? m_rem[MOD_STAGES-1] : '0;
	assign sel_shift = last_meta.hop_list >> {sel_idx, 3'b000};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= m_v[MOD_STAGES-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_port_q     <= last_meta.ok ? (sel_shift[PORT_W-1:0] & PORT_MASK) : '0;
			hop_index_q    <= sel_idx;
			flow_hash_q    <= m_hash[MOD_STAGES-1];
			bad_protocol_q <= !last_meta.ok;
		end
	end

	assign out_valid    = out_valid_q;
	assign out_port     = out_port_q;
	assign hop_index    = hop_index_q;
	assign flow_hash    = flow_hash_q;
	assign bad_protocol = bad_protocol_q;

endmodule
